>>> hdl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the polygon rectangle clipper
// Beat payloads, vertex storage format, sequencer states, divider handshake.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int MAX_OUT_VERTICES = 32;
    localparam int COORD_BITS       = 16;
    localparam int IDX_W            = $clog2(MAX_OUT_VERTICES);
    localparam int CNT_W            = IDX_W + 1;
    localparam int DIF_W            = COORD_BITS + 1;
    localparam int PROD_W           = 2 * DIF_W;
    localparam int NUM_W            = PROD_W + 2;
    localparam int AREA_W           = PROD_W + IDX_W;
    localparam int QUO_W            = COORD_BITS + 1;
    localparam int QCNT_W           = $clog2(QUO_W + 1);
    localparam int PADDR_W          = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIF_W-1:0]      dif_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vtx_t;

    typedef struct packed {
        coord_t vertex_x;
        coord_t vertex_y;
        logic   final_vertex;
    } vtx_in_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   last_out;
        logic   result_empty;
        logic   overflow;
    } vtx_out_t;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FIRST,
        ST_CAP,
        ST_EDGE,
        ST_MUL,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PUSHB,
        ST_ADV,
        ST_ORD,
        ST_OWR,
        ST_OEMPTY
    } prc_state_t;

    typedef struct packed {
        logic                     start;
        logic signed [NUM_W-1:0]  num;
        dif_t                     den;
    } div_req_t;

    typedef struct packed {
        logic   done;
        coord_t quo;
    } div_rsp_t;

endpackage

>>> hdl/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div: rounding signed divider for edge intersections
// Quotient of num/den rounded to nearest, ties away from zero, one bit a cycle.
// ----------------------------------------------------------------------------
module prc_div
    import prc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  prep_reg, prep_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                  sign_reg;
    logic [COORD_BITS-1:0] den_reg;
    logic [NUM_W-1:0]      mag_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [QUO_W-1:0]      shf_reg;
    logic [QUO_W-1:0]      quo_reg;

    logic [NUM_W-1:0]      num_abs;
    dif_t                  den_abs;
    logic [NUM_W-1:0]      tot;
    logic [COORD_BITS:0]   rs;
    logic [COORD_BITS:0]   rs_diff;
    logic                  ge;
    logic [QUO_W-1:0]      q_signed;

    assign num_abs = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
    assign den_abs = req.den[DIF_W-1] ? -req.den : req.den;
    assign tot     = mag_reg + NUM_W'(den_reg >> 1);
    assign rs      = {rem_reg, shf_reg[QUO_W-1]};
    assign rs_diff = rs - {1'b0, den_reg};
    assign ge      = (rs >= {1'b0, den_reg});

    always_comb
    begin
        prep_next = 1'b0;
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            prep_next = 1'b1;
        end
        else if (prep_reg)
        begin
            run_next = 1'b1;
            cnt_next = QCNT_W'(QUO_W);
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            prep_reg <= prep_next;
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mag_reg  <= num_abs;
            den_reg  <= den_abs[COORD_BITS-1:0];
            sign_reg <= req.num[NUM_W-1] ^ req.den[DIF_W-1];
            quo_reg  <= '0;
        end
        else if (prep_reg)
        begin
            // the rounded quotient fits QUO_W bits, so the top part is below den
            rem_reg <= tot[QUO_W+COORD_BITS-1:QUO_W];
            shf_reg <= tot[QUO_W-1:0];
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? rs_diff[COORD_BITS-1:0] : rs[COORD_BITS-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            shf_reg <= shf_reg << 1;
        end
    end

    assign q_signed = sign_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = q_signed[COORD_BITS-1:0];

endmodule

>>> hdl/polygon_rect_clipper.sv
// ----------------------------------------------------------------------------
// polygon_rect_clipper: clips a polygon against a rectangular window
// Loads vertices, orients them clockwise, clips left/top/right/bottom.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one vertex each; the beat with final_vertex set closes
//   the polygon. in_stall stays low while vertices load (one beat a cycle)
//   and goes high while the polygon is oriented, clipped and emitted.
//   Output beats carry the clipped vertices in order, last_out on the final
//   one, or a single beat with result_empty set. overflow marks a polygon
//   whose vertex stores ran full and dropped vertices.
//   The area pass takes an edge step and an advance step per vertex; each
//   of the four clip passes does the same and adds, for every intersection,
//   a multiply, a sum and a run of the bit-serial divider; emission reads
//   each vertex from store A, then writes it to the output. Each pass reads one
//   vertex store through its single read port, one vertex per edge step.
//   The output register holds a beat while out_stall is high and the
//   sequencer waits for it; the next polygon may load meanwhile.
//   Reset clears the window to x 0..32767, y 0..32767 and empties the
//   vertex count; the stores need no clearing pass.
// ----------------------------------------------------------------------------
module polygon_rect_clipper
    import prc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  vtx_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output vtx_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] PASS_LEFT   = 2'd0;
    localparam logic [1:0] PASS_TOP    = 2'd1;
    localparam logic [1:0] PASS_RIGHT  = 2'd2;
    localparam logic [1:0] PASS_BOTTOM = 2'd3;

    // configuration
    coord_t x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= coord_t'(0);
            x_max_reg <= coord_t'(32767);
            y_min_reg <= coord_t'(0);
            y_max_reg <= coord_t'(32767);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_X_MIN: x_min_reg <= pwdata[COORD_BITS-1:0];
                REG_X_MAX: x_max_reg <= pwdata[COORD_BITS-1:0];
                REG_Y_MIN: y_min_reg <= pwdata[COORD_BITS-1:0];
                REG_Y_MAX: y_max_reg <= pwdata[COORD_BITS-1:0];
                default:   x_min_reg <= x_min_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_X_MIN: prdata = {{(32-COORD_BITS){1'b0}}, x_min_reg};
            REG_X_MAX: prdata = {{(32-COORD_BITS){1'b0}}, x_max_reg};
            REG_Y_MIN: prdata = {{(32-COORD_BITS){1'b0}}, y_min_reg};
            REG_Y_MAX: prdata = {{(32-COORD_BITS){1'b0}}, y_max_reg};
            default:   prdata = '0;
        endcase
    end

    // sequencer state
    prc_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    vcount_reg, vcount_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    ocnt_reg, ocnt_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [1:0]          pass_reg, pass_next;
    logic                area_mode_reg, area_mode_next;
    logic                rev_reg, rev_next;
    logic                out_valid_reg, out_valid_next;
    // datapath
    logic signed [AREA_W-1:0] area_reg, area_next;
    vtx_t                a_reg, a_next;
    vtx_t                b_reg, b_next;
    vtx_t                first_reg, first_next;
    logic                ib_reg, ib_next;
    dif_t                d_reg, d_next;
    dif_t                dw_reg, dw_next;
    dif_t                dv_reg, dv_next;
    coord_t              wa_reg, wa_next;
    logic signed [PROD_W-1:0] pa_reg, pa_next;
    logic signed [PROD_W-1:0] pb_reg, pb_next;
    logic signed [NUM_W-1:0]  num_reg, num_next;
    vtx_out_t            out_reg, out_next;

    // vertex stores
    vtx_t                store_a_mem [MAX_OUT_VERTICES];
    vtx_t                store_b_mem [MAX_OUT_VERTICES];
    vtx_t                a_rd_reg, b_rd_reg;
    logic                a_we, b_we, a_re, b_re;
    logic [IDX_W-1:0]    a_waddr, a_raddr, src_idx;
    vtx_t                a_wdata;

    logic                load_fire, load_wr;
    logic                push_en, push_wr;
    vtx_t                push_data;
    logic                rd_en, ord_rd;
    logic [CNT_W-1:0]    rd_k, rev_k;
    logic                slot_free;
    logic                src_is_b;
    vtx_t                rdata, b_cur;
    logic                last_edge;
    logic                axis;
    coord_t              cval;
    dif_t                mval;
    logic                ia_cur, ib_cur;
    coord_t              va, vb, wa, wb;
    dif_t                mul1_a, mul1_b, mul2_a, mul2_b;
    logic signed [PROD_W-1:0] prod1, prod2;
    logic [CNT_W-1:0]    i_inc;
    logic                trav_done;
    logic                out_last;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    function automatic logic is_in(input vtx_t p, input logic ax, input coord_t c,
                                   input dif_t m);
        coord_t v;
        dif_t   s;
        v = ax ? p.y : p.x;
        s = DIF_W'(v) - DIF_W'(c);
        return (m > 0 && s < 0) || (m < 0 && s > 0);
    endfunction

    always_comb
    begin
        case (pass_reg)
            PASS_LEFT:
            begin
                axis = 1'b0;
                cval = x_min_reg;
                mval = DIF_W'(y_min_reg) - DIF_W'(y_max_reg);
            end
            PASS_TOP:
            begin
                axis = 1'b1;
                cval = y_max_reg;
                mval = DIF_W'(x_max_reg) - DIF_W'(x_min_reg);
            end
            PASS_RIGHT:
            begin
                axis = 1'b0;
                cval = x_max_reg;
                mval = DIF_W'(y_max_reg) - DIF_W'(y_min_reg);
            end
            default:
            begin
                axis = 1'b1;
                cval = y_min_reg;
                mval = DIF_W'(x_min_reg) - DIF_W'(x_max_reg);
            end
        endcase
    end

    assign load_fire = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign src_is_b  = !area_mode_reg && pass_reg[0];
    assign rdata     = src_is_b ? b_rd_reg : a_rd_reg;
    assign last_edge = (i_reg + 1'b1 == n_reg);
    assign b_cur     = last_edge ? first_reg : rdata;
    assign ia_cur    = is_in(a_reg, axis, cval, mval);
    assign ib_cur    = is_in(b_cur, axis, cval, mval);
    assign va        = axis ? a_reg.y : a_reg.x;
    assign vb        = axis ? b_cur.y : b_cur.x;
    assign wa        = axis ? a_reg.x : a_reg.y;
    assign wb        = axis ? b_cur.x : b_cur.y;
    assign i_inc     = i_reg + 1'b1;
    assign trav_done = (i_inc == n_reg);
    assign out_last  = (i_reg + 1'b1 == n_reg);
    assign prod1     = mul1_a * mul1_b;
    assign prod2     = mul2_a * mul2_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (load_fire && in_data.final_vertex)
                    state_next = ST_FIRST;
            ST_FIRST:
                if (n_reg == '0)
                    state_next = (pass_reg == PASS_BOTTOM) ? ST_OEMPTY : ST_FIRST;
                else
                    state_next = ST_CAP;
            ST_CAP:
                state_next = ST_EDGE;
            ST_EDGE:
                if (!area_mode_reg && (ia_cur != ib_cur))
                    state_next = ST_MUL;
                else
                    state_next = ST_ADV;
            ST_MUL:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_DIV_GO;
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_rsp.done)
                    state_next = ib_reg ? ST_PUSHB : ST_ADV;
            ST_PUSHB:
                state_next = ST_ADV;
            ST_ADV:
                if (!trav_done)
                    state_next = ST_EDGE;
                else if (area_mode_reg || pass_reg != PASS_BOTTOM)
                    state_next = ST_FIRST;
                else
                    state_next = (ocnt_reg == '0) ? ST_OEMPTY : ST_ORD;
            ST_ORD:
                state_next = ST_OWR;
            ST_OWR:
                if (slot_free)
                    state_next = out_last ? ST_LOAD : ST_ORD;
            ST_OEMPTY:
                if (slot_free)
                    state_next = ST_LOAD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        vcount_next    = vcount_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        ocnt_next      = ocnt_reg;
        i_next         = i_reg;
        pass_next      = pass_reg;
        area_mode_next = area_mode_reg;
        rev_next       = rev_reg;
        area_next      = area_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        first_next     = first_reg;
        ib_next        = ib_reg;
        d_next         = d_reg;
        dw_next        = dw_reg;
        dv_next        = dv_reg;
        wa_next        = wa_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        num_next       = num_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        load_wr        = 1'b0;
        push_en        = 1'b0;
        push_data      = b_reg;
        rd_en          = 1'b0;
        rd_k           = '0;
        ord_rd         = 1'b0;
        mul1_a         = '0;
        mul1_b         = '0;
        mul2_a         = '0;
        mul2_b         = '0;
        div_req.start  = 1'b0;
        div_req.num    = num_reg;
        div_req.den    = d_reg;
        in_stall       = (state_reg != ST_LOAD);

        case (state_reg)
            ST_LOAD:
                if (load_fire)
                begin
                    if (vcount_reg < CNT_W'(MAX_OUT_VERTICES))
                    begin
                        load_wr     = 1'b1;
                        vcount_next = vcount_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_data.final_vertex)
                    begin
                        n_next         = (vcount_reg < CNT_W'(MAX_OUT_VERTICES)) ?
                                         vcount_reg + 1'b1 : vcount_reg;
                        area_mode_next = 1'b1;
                        area_next      = '0;
                        pass_next      = PASS_LEFT;
                    end
                end
            ST_FIRST:
                if (n_reg == '0)
                begin
                    // empty polygon: the pass yields nothing
                    ocnt_next = '0;
                    if (pass_reg != PASS_BOTTOM)
                        pass_next = pass_reg + 1'b1;
                end
                else
                begin
                    rd_en = 1'b1;
                    rd_k  = '0;
                end
            ST_CAP:
            begin
                first_next = rdata;
                a_next     = rdata;
                i_next     = '0;
                if (n_reg > CNT_W'(1))
                begin
                    rd_en = 1'b1;
                    rd_k  = CNT_W'(1);
                end
            end
            ST_EDGE:
            begin
                b_next = b_cur;
                if (area_mode_reg)
                begin
                    mul1_a  = DIF_W'(a_reg.x);
                    mul1_b  = DIF_W'(b_cur.y);
                    mul2_a  = DIF_W'(b_cur.x);
                    mul2_b  = DIF_W'(a_reg.y);
                    pa_next = prod1;
                    pb_next = prod2;
                end
                else
                begin
                    ib_next = ib_cur;
                    d_next  = DIF_W'(va) - DIF_W'(vb);
                    dw_next = DIF_W'(wb) - DIF_W'(wa);
                    dv_next = DIF_W'(va) - DIF_W'(cval);
                    wa_next = wa;
                    if (ia_cur && ib_cur)
                    begin
                        push_en   = 1'b1;
                        push_data = b_cur;
                    end
                end
            end
            ST_MUL:
            begin
                mul1_a  = DIF_W'(wa_reg);
                mul1_b  = d_reg;
                mul2_a  = dw_reg;
                mul2_b  = dv_reg;
                pa_next = prod1;
                pb_next = prod2;
            end
            ST_SUM:
                num_next = NUM_W'(pa_reg) + NUM_W'(pb_reg);
            ST_DIV_GO:
                div_req.start = 1'b1;
            ST_DIV_WAIT:
                if (div_rsp.done)
                begin
                    push_en = 1'b1;
                    if (axis)
                    begin
                        push_data.x = div_rsp.quo;
                        push_data.y = cval;
                    end
                    else
                    begin
                        push_data.x = cval;
                        push_data.y = div_rsp.quo;
                    end
                end
            ST_PUSHB:
            begin
                push_en   = 1'b1;
                push_data = b_reg;
            end
            ST_ADV:
            begin
                a_next = b_reg;
                if (area_mode_reg)
                    area_next = area_reg + AREA_W'(pa_reg) - AREA_W'(pb_reg);
                if (!trav_done)
                begin
                    i_next = i_inc;
                    if (i_inc + 1'b1 < n_reg)
                    begin
                        rd_en = 1'b1;
                        rd_k  = i_inc + 1'b1;
                    end
                end
                else if (area_mode_reg)
                begin
                    // clockwise already when the doubled area is negative
                    area_mode_next = 1'b0;
                    rev_next       = !area_next[AREA_W-1];
                    pass_next      = PASS_LEFT;
                    ocnt_next      = '0;
                end
                else
                begin
                    n_next    = ocnt_reg;
                    ocnt_next = '0;
                    i_next    = '0;
                    if (pass_reg != PASS_BOTTOM)
                        pass_next = pass_reg + 1'b1;
                end
            end
            ST_ORD:
                ord_rd = 1'b1;
            ST_OWR:
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_x        = a_rd_reg.x;
                    out_next.out_y        = a_rd_reg.y;
                    out_next.last_out     = out_last;
                    out_next.result_empty = 1'b0;
                    out_next.overflow     = ovf_reg;
                    i_next                = i_reg + 1'b1;
                    if (out_last)
                    begin
                        vcount_next = '0;
                        ovf_next    = 1'b0;
                    end
                end
            ST_OEMPTY:
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.out_x        = '0;
                    out_next.out_y        = '0;
                    out_next.last_out     = 1'b1;
                    out_next.result_empty = 1'b1;
                    out_next.overflow     = ovf_reg;
                    vcount_next           = '0;
                    ovf_next              = 1'b0;
                end
            default:
                in_stall = 1'b1;
        endcase

        // drop a pushed vertex when the target store is full
        push_wr = push_en && (ocnt_reg < CNT_W'(MAX_OUT_VERTICES));
        if (push_en)
        begin
            if (push_wr)
                ocnt_next = ocnt_reg + 1'b1;
            else
                ovf_next = 1'b1;
        end
    end

    // store ports: the first clip pass walks the source backwards when reversing
    assign rev_k   = n_reg - CNT_W'(1) - rd_k;
    assign src_idx = (rev_reg && !area_mode_reg && pass_reg == PASS_LEFT) ?
                     rev_k[IDX_W-1:0] : rd_k[IDX_W-1:0];
    assign a_re    = ord_rd || (rd_en && !src_is_b);
    assign b_re    = rd_en && src_is_b;
    assign a_raddr = ord_rd ? i_reg[IDX_W-1:0] : src_idx;
    assign a_we    = load_wr || (push_wr && pass_reg[0]);
    assign b_we    = push_wr && !pass_reg[0];
    assign a_waddr = load_wr ? vcount_reg[IDX_W-1:0] : ocnt_reg[IDX_W-1:0];
    assign a_wdata = load_wr ? vtx_t'({in_data.vertex_x, in_data.vertex_y}) : push_data;

    always_ff @(posedge clk)
    begin
        if (a_we)
            store_a_mem[a_waddr] <= a_wdata;
        if (a_re)
            a_rd_reg <= store_a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            store_b_mem[ocnt_reg[IDX_W-1:0]] <= push_data;
        if (b_re)
            b_rd_reg <= store_b_mem[src_idx];
    end

    prc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= '0;
            ocnt_reg      <= '0;
            i_reg         <= '0;
            pass_reg      <= PASS_LEFT;
            area_mode_reg <= 1'b0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            ocnt_reg      <= ocnt_next;
            i_reg         <= i_next;
            pass_reg      <= pass_next;
            area_mode_reg <= area_mode_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        area_reg  <= area_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        first_reg <= first_next;
        ib_reg    <= ib_next;
        d_reg     <= d_next;
        dw_reg    <= dw_next;
        dv_reg    <= dv_next;
        wa_reg    <= wa_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        num_reg   <= num_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (vcount_reg <= CNT_W'(MAX_OUT_VERTICES)) && (ocnt_reg <= CNT_W'(MAX_OUT_VERTICES)))
        else $error("vertex count beyond store depth");

    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EDGE) |-> (i_reg < n_reg))
        else $error("edge index past polygon size");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OWR && slot_free && out_last) |=>
        (vcount_reg == '0 && !ovf_reg && state_reg == ST_LOAD))
        else $error("polygon state not cleared after last beat");

    a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> !load_wr)
        else $error("vertex loaded while clipping");

endmodule
